// File: rtl/assert_macros.svh
// Assertion helpers for the queue block. Both sample on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define FQSR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fqsr assertion failed");

// Checked at every edge, reset included.
`define FQSR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("fqsr assertion failed");

`endif

// File: rtl/fqsr_pkg.sv
`default_nettype none

package fqsr_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_BITS  = 32;
    localparam int DATA_BITS = 32;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ENTRY_W = KEY_BITS + DATA_BITS;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_SRCH = 2'd2,
        OP_REV  = 2'd3
    } opcode_t;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_DEQ  = 5'b00100,
        S_SCAN = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    // Physical slot that sits pos places from slot base, walking toward the
    // back of the queue in the current storage direction.
    function automatic logic [IDX_W-1:0] step_slot(
        input logic [IDX_W-1:0] base,
        input logic             rev,
        input logic [CNT_W-1:0] pos
    );
        logic [CNT_W:0] sum;
        if (rev)
            sum = (CNT_W+1)'(base) + (CNT_W+1)'(DEPTH) - (CNT_W+1)'(pos);
        else
            sum = (CNT_W+1)'(base) + (CNT_W+1)'(pos);
        if (sum >= (CNT_W+1)'(DEPTH))
            sum = sum - (CNT_W+1)'(DEPTH);
        return sum[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/fifo_queue_with_search_reverse.sv
// Enqueue, reverse and the empty cases go from the execute state to the result;
// dequeue passes through a read state first, and a search walks up to count entries.
// One item is in work at a time; the next is taken once the block is back in idle
// after the result is registered; the walk is bound by the single read port.
// Reset clears pointers, count, direction and the output valid flag; the entry
// memory is not cleared and needs no pass after reset.
`default_nettype none

`include "assert_macros.svh"

module fifo_queue_with_search_reverse
    import fqsr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [31:0] item_key,
    input  wire logic [31:0] item_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic             found,
    output logic [31:0]      out_key,
    output logic [31:0]      out_data,
    output logic [4:0]       entry_count
);

    state_t state_reg, state_next;

    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             rev_reg, rev_next;

    opcode_t              op_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [DATA_BITS-1:0] data_reg;

    status_t              res_status_reg, res_status_next;
    logic                 res_found_reg, res_found_next;
    logic [KEY_BITS-1:0]  res_key_reg, res_key_next;
    logic [DATA_BITS-1:0] res_data_reg, res_data_next;

    logic [IDX_W-1:0] scan_slot_reg, scan_slot_next;
    logic [CNT_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             rd_last_reg, rd_last_next;

    logic             out_valid_reg;
    status_t          out_status_reg;
    logic             out_found_reg;
    logic [31:0]      out_key_reg;
    logic [31:0]      out_data_reg;
    logic [4:0]       out_count_reg;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;
    logic [KEY_BITS-1:0]  rd_key;
    logic [DATA_BITS-1:0] rd_data;

    logic in_fire;
    logic out_load;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_load = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    assign rd_key  = mem_rdata[ENTRY_W-1:DATA_BITS];
    assign rd_data = mem_rdata[DATA_BITS-1:0];

    fqsr_ram #(
        .DEPTH(DEPTH),
        .WIDTH(ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata ({key_reg, data_reg}),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        fill_next       = fill_reg;
        rev_next        = rev_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_key_next    = res_key_reg;
        res_data_next   = res_data_reg;
        scan_slot_next  = scan_slot_reg;
        issue_cnt_next  = issue_cnt_reg;
        rd_pend_next    = 1'b0;
        rd_last_next    = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = step_slot(front_reg, rev_reg, fill_reg);
        mem_re          = 1'b0;
        mem_raddr       = front_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // Unless overwritten below, the input item is echoed.
                res_status_next = ST_OK;
                res_found_next  = 1'b0;
                res_key_next    = key_reg;
                res_data_next   = data_reg;
                state_next      = S_FIN;
                unique case (op_reg)
                    OP_ENQ:
                    begin
                        if (fill_reg >= DEPTH_CNT)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    OP_DEQ:
                    begin
                        if (fill_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            front_next = step_slot(front_reg, rev_reg, CNT_W'(1));
                            fill_next  = fill_reg - 1'b1;
                            state_next = S_DEQ;
                        end
                    end
                    OP_SRCH:
                    begin
                        if (fill_reg != '0)
                        begin
                            scan_slot_next = front_reg;
                            issue_cnt_next = '0;
                            state_next     = S_SCAN;
                        end
                    end
                    OP_REV:
                    begin
                        // The back entry becomes the front and the storage
                        // direction flips; nothing moves in memory.
                        if (fill_reg > CNT_W'(1))
                        begin
                            front_next = step_slot(front_reg, rev_reg, fill_reg - 1'b1);
                            rev_next   = !rev_reg;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_DEQ:
            begin
                res_key_next  = rd_key;
                res_data_next = rd_data;
                state_next    = S_FIN;
            end
            S_SCAN:
            begin
                // One read is issued per cycle while the entry read the cycle
                // before is compared, so the walk covers one entry a cycle.
                if (issue_cnt_reg < fill_reg)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = scan_slot_reg;
                    scan_slot_next = step_slot(scan_slot_reg, rev_reg, CNT_W'(1));
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    rd_pend_next   = 1'b1;
                    rd_last_next   = (issue_cnt_reg == fill_reg - 1'b1);
                end
                if (rd_pend_reg)
                begin
                    res_key_next  = rd_key;
                    res_data_next = rd_data;
                    if (rd_key == key_reg)
                    begin
                        res_found_next = 1'b1;
                        state_next     = S_FIN;
                        rd_pend_next   = 1'b0;
                    end
                    else if (rd_last_reg)
                    begin
                        state_next   = S_FIN;
                        rd_pend_next = 1'b0;
                    end
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            fill_reg      <= '0;
            rev_reg       <= 1'b0;
            rd_pend_reg   <= 1'b0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            fill_reg    <= fill_next;
            rev_reg     <= rev_next;
            rd_pend_reg <= rd_pend_next;
            rd_last_reg <= rd_last_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg   <= opcode_t'(opcode);
            key_reg  <= item_key[KEY_BITS-1:0];
            data_reg <= item_data[DATA_BITS-1:0];
        end
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_key_reg    <= res_key_next;
        res_data_reg   <= res_data_next;
        scan_slot_reg  <= scan_slot_next;
        issue_cnt_reg  <= issue_cnt_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= res_found_reg;
            out_key_reg    <= 32'(res_key_reg);
            out_data_reg   <= 32'(res_data_reg);
            out_count_reg  <= 5'(fill_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign found       = out_found_reg;
    assign out_key     = out_key_reg;
    assign out_data    = out_data_reg;
    assign entry_count = out_count_reg;

    `FQSR_ASSERT(a_fill_bound, fill_reg <= DEPTH_CNT)
    `FQSR_ASSERT(a_found_ok, (out_valid_reg && out_found_reg) |-> (out_status_reg == ST_OK))
    `FQSR_ASSERT(a_enq_count,
        (state_reg == S_EXEC && op_reg == OP_ENQ && fill_reg < DEPTH_CNT)
        |=> (fill_reg == $past(fill_reg) + 1'b1))
    `FQSR_ASSERT(a_read_scope, rd_pend_reg |-> (state_reg == S_SCAN))

endmodule

`default_nettype wire

// File: rtl/fqsr_ram.sv
`default_nettype none

module fqsr_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: verif/fifo_queue_with_search_reverse_tb.sv
`default_nettype none

module fifo_queue_with_search_reverse_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fqsr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        status_t          res_status;
        logic             res_found;
        logic [31:0]      res_key;
        logic [31:0]      res_data;
        logic [CNT_W-1:0] res_count;
    } queue_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [31:0] item_key;
    logic [31:0] item_data;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic        found;
    logic [31:0] out_key;
    logic [31:0] out_data;
    logic [4:0]  entry_count;

    fifo_queue_with_search_reverse dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .item_key    (item_key),
        .item_data   (item_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found       (found),
        .out_key     (out_key),
        .out_data    (out_data),
        .entry_count (entry_count)
    );

    // Shadow copy of the queue contents and pointers.
    logic [KEY_BITS-1:0]  shadow_key  [DEPTH];
    logic [DATA_BITS-1:0] shadow_data [DEPTH];
    logic [IDX_W-1:0]     shadow_front;
    logic [CNT_W-1:0]     shadow_count;
    logic                 shadow_rev;

    queue_result_t pending_results[$];
    int            mismatch_count;
    int            cycle_count;
    int            tx_idle_pct;
    int            rx_idle_pct;
    int            rx_hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Physical slot of logical position pos, counted from the front.
    function automatic logic [IDX_W-1:0] slot_of(input int pos);
        int f;
        f = int'(shadow_front);
        if (shadow_rev)
            return IDX_W'((f + DEPTH - pos) % DEPTH);
        return IDX_W'((f + pos) % DEPTH);
    endfunction

    function automatic queue_result_t apply_queue_op(input opcode_t op, input logic [31:0] k,
                                                     input logic [31:0] d);
        queue_result_t res;
        logic [IDX_W-1:0] s;
        res.res_status = ST_OK;
        res.res_found  = 1'b0;
        res.res_key    = k;
        res.res_data   = d;
        case (op)
            OP_ENQ:
            begin
                if (shadow_count >= DEPTH_CNT)
                    res.res_status = ST_FULL;
                else
                begin
                    s = slot_of(int'(shadow_count));
                    shadow_key[s]  = k;
                    shadow_data[s] = d;
                    shadow_count   = shadow_count + 1'b1;
                end
            end
            OP_DEQ:
            begin
                if (shadow_count == 0)
                    res.res_status = ST_EMPTY;
                else
                begin
                    s = slot_of(0);
                    res.res_key  = shadow_key[s];
                    res.res_data = shadow_data[s];
                    shadow_front = slot_of(1);
                    shadow_count = shadow_count - 1'b1;
                end
            end
            OP_SRCH:
            begin
                // A miss leaves the last entry visited, which is the back.
                for (int i = 0; i < int'(shadow_count); i++)
                begin
                    s = slot_of(i);
                    res.res_key  = shadow_key[s];
                    res.res_data = shadow_data[s];
                    if (shadow_key[s] == k)
                    begin
                        res.res_found = 1'b1;
                        break;
                    end
                end
            end
            default:
            begin
                if (shadow_count > 1)
                begin
                    shadow_front = slot_of(int'(shadow_count) - 1);
                    shadow_rev   = ~shadow_rev;
                end
            end
        endcase
        res.res_count = shadow_count;
        return res;
    endfunction

    // Entered at a falling edge; returns at the falling edge after the item is taken,
    // with valid still high so that a following item can be offered without a gap.
    task automatic send_item(input opcode_t op, input logic [31:0] k, input logic [31:0] d);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        opcode    = op;
        item_key  = k;
        item_data = d;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        pending_results.push_back(apply_queue_op(op, k, d));
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_key();
        int r;
        r = $urandom_range(9);
        if (r < 5)
            return $urandom;
        if (r < 8)
            return 32'($urandom_range(7));
        return (r == 8) ? 32'h0000_0000 : 32'hFFFF_FFFF;
    endfunction

    task automatic test_empty_queue();
        send_item(OP_DEQ, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(OP_SRCH, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(OP_REV, $urandom, $urandom);
    endtask

    task automatic test_fill_to_full();
        send_item(OP_ENQ, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(OP_REV, $urandom, $urandom);
        for (int i = 1; i < DEPTH - 1; i++)
            send_item(OP_ENQ, {4'(i), 28'($urandom)}, $urandom);
        send_item(OP_ENQ, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(OP_ENQ, 32'h1234_5678, 32'h9ABC_DEF0);
    endtask

    task automatic test_search_and_reverse();
        send_item(OP_SRCH, shadow_key[slot_of(DEPTH / 2)], $urandom);
        send_item(OP_SRCH, 32'h5A5A_5A5A, $urandom);
        send_item(OP_REV, $urandom, $urandom);
        send_item(OP_DEQ, $urandom, $urandom);
    endtask

    task automatic test_random_traffic(input int n_items);
        int target;
        int r;
        opcode_t op;
        logic [31:0] k;
        target = 0;
        for (int i = 0; i < n_items; i++)
        begin
            // The fill target wanders so the queue sweeps between empty and overflowing.
            if (i % 60 == 0)
                target = $urandom_range(DEPTH + 1);
            r = $urandom_range(99);
            k = rand_key();
            if (r < 15)
            begin
                op = OP_SRCH;
                if (shadow_count != 0)
                    k = shadow_key[slot_of($urandom_range(int'(shadow_count) - 1))];
            end
            else if (r < 28)
                op = OP_SRCH;
            else if (r < 38)
                op = OP_REV;
            else if (r < 42)
                op = opcode_t'($urandom_range(3));
            else if (int'(shadow_count) < target)
                op = OP_ENQ;
            else
                op = OP_DEQ;
            send_item(op, k, $urandom);
        end
    endtask

    task automatic test_output_stall();
        rx_hold_cycles = 400;
        for (int i = 0; i < 40; i++)
            send_item((i % 5 == 4) ? OP_SRCH : OP_ENQ, rand_key(), $urandom);
    endtask

    task automatic finish_run();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        opcode         = OP_ENQ;
        item_key       = '0;
        item_data      = '0;
        mismatch_count = 0;
        tx_idle_pct    = 35;
        rx_idle_pct    = 35;
        rx_hold_cycles = 0;
        shadow_front   = '0;
        shadow_count   = '0;
        shadow_rev     = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_queue();
        test_fill_to_full();
        test_search_and_reverse();
        test_random_traffic(600);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(300);
        tx_idle_pct = 35;
        rx_idle_pct = 35;
        test_output_stall();
        test_random_traffic(460);
        finish_run();
    end

    // Receiver: random stalls, plus a counted hold-off when one is requested.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                rx_hold_cycles = rx_hold_cycles - 1;
                out_ready = 1'b0;
            end
            else
                out_ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        queue_result_t exp_res;
        queue_result_t got_res;
        if (rst_n && out_valid && out_ready)
        begin
            got_res.res_status = status;
            got_res.res_found  = found;
            got_res.res_key    = out_key;
            got_res.res_data   = out_data;
            got_res.res_count  = entry_count;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with none expected: st=%0d f=%0d k=%h d=%h n=%0d",
                             $time, status, found, out_key, out_data, entry_count);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (got_res !== exp_res)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("%0t: result differs: exp st=%0d f=%0d k=%h d=%h n=%0d",
                                 $time, exp_res.res_status, exp_res.res_found,
                                 exp_res.res_key, exp_res.res_data, exp_res.res_count);
                        $display("%0t: result differs: got st=%0d f=%0d k=%h d=%h n=%0d",
                                 $time, got_res.res_status, got_res.res_found,
                                 got_res.res_key, got_res.res_data, got_res.res_count);
                    end
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
